[design/odsc_pkg.sv]
package odsc_pkg;

  localparam int ADDR_W     = 20;
  localparam int SUM_W      = 10;
  localparam int FIFO_DEPTH = 3;

  localparam logic [ADDR_W-1:0] VIDEO_BASE_RESET = 20'hB0000;

  typedef struct packed {
    logic [8:0]  out_row;
    logic [6:0]  out_byte_col;
    logic [23:0] pixel0_rgb;
    logic [23:0] pixel1_rgb;
    logic [23:0] pixel2_rgb;
    logic [23:0] pixel3_rgb;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_byte;
  } out_item_t;

  function automatic logic [SUM_W-1:0] dither_thresh(input logic [3:0] idx);
    logic [SUM_W-1:0] t;
    case (idx)
      4'd0:    t = 10'd45;
      4'd1:    t = 10'd405;
      4'd2:    t = 10'd135;
      4'd3:    t = 10'd495;
      4'd4:    t = 10'd585;
      4'd5:    t = 10'd225;
      4'd6:    t = 10'd675;
      4'd7:    t = 10'd315;
      4'd8:    t = 10'd180;
      4'd9:    t = 10'd540;
      4'd10:   t = 10'd90;
      4'd11:   t = 10'd450;
      4'd12:   t = 10'd720;
      4'd13:   t = 10'd360;
      4'd14:   t = 10'd630;
      4'd15:   t = 10'd270;
      default: t = 10'd0;
    endcase
    return t;
  endfunction

endpackage

[design/odsc_dither.sv]
module odsc_dither
  import odsc_pkg::*;
(
  input  in_item_t   item,
  output logic [7:0] dither_byte
);

  logic [SUM_W-1:0] sums [4];

  always_comb begin
    sums[0] = SUM_W'(item.pixel0_rgb[7:0]) + SUM_W'(item.pixel0_rgb[15:8])
            + SUM_W'(item.pixel0_rgb[23:16]);
    sums[1] = SUM_W'(item.pixel1_rgb[7:0]) + SUM_W'(item.pixel1_rgb[15:8])
            + SUM_W'(item.pixel1_rgb[23:16]);
    sums[2] = SUM_W'(item.pixel2_rgb[7:0]) + SUM_W'(item.pixel2_rgb[15:8])
            + SUM_W'(item.pixel2_rgb[23:16]);
    sums[3] = SUM_W'(item.pixel3_rgb[7:0]) + SUM_W'(item.pixel3_rgb[15:8])
            + SUM_W'(item.pixel3_rgb[23:16]);
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      dither_byte[7-i] = sums[i/2] >
                         dither_thresh({item.out_row[1:0], 2'(i % 4)});
    end
  end

endmodule

[design/odsc_shadow.sv]
module odsc_shadow #(
  parameter int DEPTH = 32000,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic          busy
);

  logic [7:0]    mem [DEPTH];
  logic          busy_r;
  logic [AW-1:0] clr_cnt_r;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_comb begin
    if (busy_r) begin
      we = 1'b1;
      wa = clr_cnt_r;
      wd = '0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  assign busy = busy_r;

endmodule

[design/odsc_out_fifo.sv]
module odsc_out_fifo
  import odsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  output logic [1:0] count
);

  out_item_t  buf_r [FIFO_DEPTH];
  logic [1:0] wr_ptr_r, rd_ptr_r, cnt_r;
  logic       pop;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'(FIFO_DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

  assign out_valid = cnt_r != 2'd0;
  assign out_item  = buf_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

[design/mono_ordered_dither_scanout_top.sv]
// Ordered-dither scanout for a 1-bit display with change detection.
// Input channel (in_valid/in_stall/in_item): one output byte position per
// transfer with its row, byte column and four source RGB pixels. Items whose
// row or column is out of range are taken and dropped.
// Output channel (out_valid/out_stall/out_item): a display memory write,
// emitted only when the dithered byte differs from the shadow copy.
// Config: cfg_wr_en/cfg_wr_data load the video base address; write it only
// while the block is idle.
// Throughput: one item per cycle while in_stall is low. A result passes the
// shadow memory read stage and then the output FIFO before it is available
// for transfer. Back-to-back updates of the same byte forward the previous
// write around the memory read.
// Reset: the shadow memory is swept to zero, one entry per cycle, over all
// ROWS*BYTES_PER_ROW entries (32000 by default); in_stall is high meanwhile.
// Output stall: a three-entry FIFO absorbs results in flight; in_stall rises
// once it and the read stage could not take another result.
module mono_ordered_dither_scanout_top
  import odsc_pkg::*;
#(
  parameter int ROWS          = 400,
  parameter int BYTES_PER_ROW = 80,
  parameter int BANK_STRIDE   = 8192
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_wr_en,
  input  logic [ADDR_W-1:0] cfg_wr_data
);

  localparam int DEPTH = ROWS * BYTES_PER_ROW;
  localparam int PW    = $clog2(DEPTH);

  logic [ADDR_W-1:0] video_base_r;
  logic              in_accept, in_ok, clr_busy;
  logic [7:0]        dither_byte;
  logic [PW-1:0]     in_pos;
  logic [ADDR_W-1:0] in_off;

  logic              s1_v_r, s1_v_nxt;
  logic [PW-1:0]     s1_pos_r;
  logic [7:0]        s1_byte_r;
  logic [ADDR_W-1:0] s1_off_r;
  logic [1:0]        s1_bank_r;

  logic              fw_v_r;
  logic [PW-1:0]     fw_pos_r;
  logic [7:0]        fw_byte_r;

  logic [7:0]        shadow_rdata, old_byte;
  logic              changed;
  out_item_t         res_item;
  logic [1:0]        fifo_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_base_r <= VIDEO_BASE_RESET;
    end else if (cfg_wr_en) begin
      video_base_r <= cfg_wr_data;
    end
  end

  odsc_dither u_dither (
    .item        (in_item),
    .dither_byte (dither_byte)
  );

  assign in_stall  = clr_busy || ((3'(fifo_cnt) + 3'(s1_v_r)) >= 3'(FIFO_DEPTH));
  assign in_accept = in_valid && !in_stall;
  assign in_ok     = (32'(in_item.out_row) < ROWS) &&
                     (32'(in_item.out_byte_col) < BYTES_PER_ROW);
  assign in_pos    = PW'(32'(BYTES_PER_ROW) * 32'(in_item.out_row)
                       + 32'(in_item.out_byte_col));
  assign in_off    = ADDR_W'(32'(BYTES_PER_ROW) * 32'(in_item.out_row[8:2])
                       + 32'(in_item.out_byte_col));
  assign s1_v_nxt  = in_accept && in_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fw_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      fw_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_pos_r  <= in_pos;
    s1_byte_r <= dither_byte;
    s1_off_r  <= in_off;
    s1_bank_r <= in_item.out_row[1:0];
    fw_pos_r  <= s1_pos_r;
    fw_byte_r <= s1_byte_r;
  end

  odsc_shadow #(
    .DEPTH (DEPTH),
    .AW    (PW)
  ) u_shadow (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (in_pos),
    .rd_data (shadow_rdata),
    .wr_en   (changed),
    .wr_addr (s1_pos_r),
    .wr_data (s1_byte_r),
    .busy    (clr_busy)
  );

  assign old_byte = (fw_v_r && fw_pos_r == s1_pos_r) ? fw_byte_r : shadow_rdata;
  assign changed  = s1_v_r && (old_byte != s1_byte_r);

  always_comb begin
    res_item.write_address = video_base_r
                           + ADDR_W'(BANK_STRIDE * 32'(s1_bank_r))
                           + s1_off_r;
    res_item.write_byte    = s1_byte_r;
  end

  odsc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (changed),
    .push_item (res_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .count     (fifo_cnt)
  );

endmodule

[verif/mono_ordered_dither_scanout_top_tb.sv]
module mono_ordered_dither_scanout_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import odsc_pkg::*;

  localparam int ROWS           = 400;
  localparam int BYTES_PER_ROW  = 80;
  localparam int BANK_STRIDE    = 8192;
  localparam int SHADOW_DEPTH   = ROWS * BYTES_PER_ROW;
  localparam int MAX_GAP        = 18;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int PHASE_ITEMS    = 500;

  class scanout_scoreboard;
    logic [ADDR_W-1:0] video_base;
    logic [7:0]        shadow_bytes [SHADOW_DEPTH];
    out_item_t         pending_writes [$];
    int unsigned       bayer_level [16] = '{45, 405, 135, 495, 585, 225, 675, 315,
                                            180, 540, 90, 450, 720, 360, 630, 270};
    int unsigned       mismatches;
    int unsigned       items_taken;
    int unsigned       items_dropped;
    int unsigned       items_unchanged;
    int unsigned       writes_checked;

    function new();
      video_base = VIDEO_BASE_RESET;
      foreach (shadow_bytes[k]) shadow_bytes[k] = 8'h00;
    endfunction

    function int unsigned channel_total(logic [23:0] rgb);
      return int'(rgb[7:0]) + int'(rgb[15:8]) + int'(rgb[23:16]);
    endfunction

    function logic [7:0] dither_byte(in_item_t it);
      logic [7:0]  b;
      int unsigned sums [4];
      sums[0] = channel_total(it.pixel0_rgb);
      sums[1] = channel_total(it.pixel1_rgb);
      sums[2] = channel_total(it.pixel2_rgb);
      sums[3] = channel_total(it.pixel3_rgb);
      b = 8'h00;
      for (int i = 0; i < 8; i++) begin
        if (sums[i / 2] > bayer_level[int'(it.out_row[1:0]) * 4 + i % 4]) b[7 - i] = 1'b1;
      end
      return b;
    endfunction

    function void note_input(in_item_t it);
      logic [7:0]  b;
      int unsigned pos;
      out_item_t   w;
      items_taken++;
      if (it.out_row >= ROWS || it.out_byte_col >= BYTES_PER_ROW) begin
        items_dropped++;
        return;
      end
      b   = dither_byte(it);
      pos = int'(it.out_row) * BYTES_PER_ROW + int'(it.out_byte_col);
      if (shadow_bytes[pos] == b) begin
        items_unchanged++;
        return;
      end
      shadow_bytes[pos] = b;
      w.write_address = ADDR_W'(int'(video_base) + BANK_STRIDE * int'(it.out_row[1:0])
                                + BYTES_PER_ROW * int'(it.out_row >> 2)
                                + int'(it.out_byte_col));
      w.write_byte = b;
      pending_writes.push_back(w);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_writes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected write, expected none, actual addr %h byte %h",
                 $time, got.write_address, got.write_byte);
        return;
      end
      want = pending_writes.pop_front();
      writes_checked++;
      if (got.write_address !== want.write_address) begin
        mismatches++;
        $display("%0t: write_address expected %h actual %h",
                 $time, want.write_address, got.write_address);
      end
      if (got.write_byte !== want.write_byte) begin
        mismatches++;
        $display("%0t: write_byte expected %h actual %h (addr %h)",
                 $time, want.write_byte, got.write_byte, want.write_address);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  in_item_t          in_item     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  out_item_t         out_item;
  logic              cfg_wr_en   = 1'b0;
  logic [ADDR_W-1:0] cfg_wr_data = '0;

  scanout_scoreboard sb = new();
  in_item_t          last_item = '0;
  int                max_in_gap = MAX_GAP;
  int                max_out_gap = MAX_GAP;
  bit                hold_request = 1'b0;
  int                quiet_cycles = 0;

  mono_ordered_dither_scanout_top #(
    .ROWS         (ROWS),
    .BYTES_PER_ROW(BYTES_PER_ROW),
    .BANK_STRIDE  (BANK_STRIDE)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    bit in_xfer;
    bit out_xfer;
    in_xfer  = rst_n && in_valid && in_stall === 1'b0;
    out_xfer = rst_n && out_valid === 1'b1 && !out_stall;
    if (in_xfer) sb.note_input(in_item);
    if (out_xfer) sb.check_result(out_item);
    if (in_xfer || out_xfer) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d writes outstanding",
               $time, quiet_cycles, sb.pending_writes.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // receiver: random hold per transfer, one long hold on request
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = $urandom_range(0, max_out_gap);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  function automatic logic [23:0] rgb_with_sum(int s);
    int r;
    int g;
    int b;
    if (s < 0) s = 0;
    if (s > 765) s = 765;
    r = (s > 255) ? 255 : s;
    s = s - r;
    g = (s > 255) ? 255 : s;
    b = s - g;
    case ($urandom_range(0, 2))
      0:       return {8'(b), 8'(g), 8'(r)};
      1:       return {8'(r), 8'(b), 8'(g)};
      default: return {8'(g), 8'(r), 8'(b)};
    endcase
  endfunction

  function automatic logic [23:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2, 3:    return rgb_with_sum(int'(sb.bayer_level[$urandom_range(0, 15)])
                                   + $urandom_range(0, 2) - 1);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_item(int row, int col, logic [23:0] p0, logic [23:0] p1,
                                         logic [23:0] p2, logic [23:0] p3);
    in_item_t it;
    it.out_row      = 9'(row);
    it.out_byte_col = 7'(col);
    it.pixel0_rgb   = p0;
    it.pixel1_rgb   = p1;
    it.pixel2_rgb   = p2;
    it.pixel3_rgb   = p3;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       kind;
    kind = $urandom_range(0, 99);
    if (kind < 10) return last_item;
    it = make_item($urandom_range(0, ROWS - 1), $urandom_range(0, BYTES_PER_ROW - 1),
                   random_pixel(), random_pixel(), random_pixel(), random_pixel());
    if (kind < 16) begin
      it.out_row = 9'($urandom_range(ROWS, 511));
    end else if (kind < 22) begin
      it.out_byte_col = 7'($urandom_range(BYTES_PER_ROW, 127));
    end else if (kind < 45) begin
      it.out_row      = 9'($urandom_range(0, 7));
      it.out_byte_col = 7'($urandom_range(0, 3));
    end
    last_item = it;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = $urandom_range(0, max_in_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // hold input until every predicted write has come out and the pipe is quiet
  task automatic drain_writes();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_video_base(logic [ADDR_W-1:0] base);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= base;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.video_base = base;
  endtask

  task automatic run_random(int count, int hold_at);
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) hold_request = 1'b1;
      if (k > 0 && k % 250 == 0) drain_writes();
      send_item(random_item());
    end
    drain_writes();
  endtask

  initial begin
    logic [23:0] edge_px [4];
    int          lvl_row;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(make_item(0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_item(make_item(0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_item(make_item(0, 0, 24'h000000, 24'h000000, 24'h000000, 24'h000000));
    send_item(make_item(ROWS - 1, BYTES_PER_ROW - 1, 24'hFFFFFF, 24'hFFFFFF,
                        24'hFFFFFF, 24'hFFFFFF));
    send_item(make_item(ROWS, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_item(make_item(511, 127, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_item(make_item(0, BYTES_PER_ROW, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_item(make_item(3, 64, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h808080));
    send_item(make_item(2, 3, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000));
    send_item(make_item(2, 3, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF));
    send_item(make_item(2, 3, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000));
    send_item(make_item(2, 3, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000));
    send_item(make_item(256, 32, 24'h7F7F7F, 24'h808080, 24'hFF00FF, 24'h00FFFF));
    for (int r = 4; r < 8; r++) begin
      lvl_row = (r % 4) * 4;
      for (int d = 0; d < 2; d++) begin
        for (int p = 0; p < 4; p++)
          edge_px[p] = rgb_with_sum(int'(sb.bayer_level[lvl_row + (2 * p) % 4]) + d);
        send_item(make_item(r, 10, edge_px[0], edge_px[1], edge_px[2], edge_px[3]));
      end
    end
    drain_writes();

    write_video_base(20'hFFFFF);
    run_random(PHASE_ITEMS, 100);

    write_video_base(20'h00000);
    max_in_gap  = 0;
    max_out_gap = 0;
    run_random(PHASE_ITEMS, -1);
    max_in_gap  = MAX_GAP;
    max_out_gap = MAX_GAP;

    write_video_base(20'($urandom));
    run_random(PHASE_ITEMS, -1);

    write_video_base(VIDEO_BASE_RESET);
    run_random(PHASE_ITEMS, -1);

    repeat (10) @(posedge clk);
    if (sb.pending_writes.size() != 0)
      $display("%0t: %0d expected writes never arrived", $time, sb.pending_writes.size());
    $display("Covered %0d items (%0d out of range, %0d unchanged), %0d writes checked,",
             sb.items_taken, sb.items_dropped, sb.items_unchanged, sb.writes_checked);
    $display("base at reset value, all ones, zero and random; one %0d-cycle output hold",
             LONG_HOLD);
    if (sb.mismatches == 0 && sb.pending_writes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
design/odsc_pkg.sv
design/odsc_dither.sv
design/odsc_shadow.sv
design/odsc_out_fifo.sv
design/mono_ordered_dither_scanout_top.sv
verif/mono_ordered_dither_scanout_top_tb.sv
